// ----- design/mlt_pkg.sv -----
// ----------------------------------------------------------------------------
// MAC learning table package
// Shared widths, command codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package mlt_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int MAC_W             = 48;
  localparam int IDX_OUT_W         = 4;
  localparam int CNT_OUT_W         = 5;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_ADD    = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;    // latch a new item and restart the scan
    logic scan_en;  // let the scan pipeline advance
    logic finish;   // resolve the item and load the result registers
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_hit;   // compared entry matches the item address
    logic scan_miss;  // all filled entries compared without a match
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- design/mlt_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without re_i.
// ----------------------------------------------------------------------------
`default_nettype none

module mlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- design/mlt_ctrl.sv -----
// ----------------------------------------------------------------------------
// MAC learning table controller
// Sequences acceptance, the entry scan and the hand-off to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mlt_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output mlt_pkg::dp_cmd_t     cmd_o,
  input  wire mlt_pkg::dp_sts_t sts_i
);
  import mlt_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic done, slot_free, accept;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign done        = sts_i.scan_hit || sts_i.scan_miss;
  // The result register can take a new item when empty or being emptied.
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && out_stall_i;
    cmd_o.start   = 1'b0;
    cmd_o.scan_en = 1'b0;
    cmd_o.finish  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Freeze the scan while a finished item waits for the result slot.
        cmd_o.scan_en = slot_free || !done;
        if (done && slot_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/mlt_dp.sv -----
// ----------------------------------------------------------------------------
// MAC learning table datapath
// Address store, fill count, pipelined entry scan and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mlt_dp #(
  parameter int TABLE_ENTRIES = mlt_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire mlt_pkg::dp_cmd_t             cmd_i,
  output mlt_pkg::dp_sts_t                  sts_o,
  input  wire logic                         command_i,
  input  wire logic [mlt_pkg::MAC_W-1:0]    mac_address_i,
  output logic                              hit_o,
  output logic                              added_o,
  output logic                              table_full_o,
  output logic [mlt_pkg::IDX_OUT_W-1:0]     entry_index_o,
  output logic [mlt_pkg::CNT_OUT_W-1:0]     entry_count_o
);
  import mlt_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] NMAX = CNT_W'(TABLE_ENTRIES);

  logic             cmd_q;
  logic [MAC_W-1:0] mac_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rptr_q;
  logic [IDX_W-1:0] ridx_q;
  logic             rv_q;
  logic             rd_en;
  logic             wr_en;
  logic [MAC_W-1:0] rdata;

  logic             res_hit_q, res_added_q, res_full_q;
  logic [IDX_W-1:0] res_idx_q;

  // A read is issued for every filled entry not yet visited.
  assign rd_en = cmd_i.scan_en && (rptr_q < count_q);

  assign sts_o.scan_hit  = rv_q && (rdata == mac_q);
  assign sts_o.scan_miss = !rv_q && (rptr_q >= count_q);

  assign wr_en   = cmd_i.finish && !sts_o.scan_hit && (cmd_q == CMD_ADD)
                   && (count_q < NMAX);
  assign count_d = wr_en ? (count_q + 1'b1) : count_q;

  mlt_ram #(
    .WIDTH (MAC_W),
    .DEPTH (TABLE_ENTRIES),
    .AW    (IDX_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (mac_q),
    .re_i    (rd_en),
    .raddr_i (rptr_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      rptr_q  <= '0;
      rv_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.start) begin
        rptr_q <= '0;
        rv_q   <= 1'b0;
      end else if (cmd_i.scan_en) begin
        rv_q <= rd_en;
        if (rd_en) begin
          rptr_q <= rptr_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cmd_q <= command_i;
      mac_q <= mac_address_i;
    end
    if (rd_en) begin
      ridx_q <= rptr_q[IDX_W-1:0];
    end
    if (cmd_i.finish) begin
      res_hit_q   <= sts_o.scan_hit;
      res_added_q <= wr_en;
      res_full_q  <= !sts_o.scan_hit && (cmd_q == CMD_ADD) && (count_q >= NMAX);
      if (sts_o.scan_hit) begin
        res_idx_q <= ridx_q;
      end else if (wr_en) begin
        res_idx_q <= count_q[IDX_W-1:0];
      end else begin
        res_idx_q <= '0;
      end
    end
  end

  assign hit_o         = res_hit_q;
  assign added_o       = res_added_q;
  assign table_full_o  = res_full_q;
  assign entry_index_o = IDX_OUT_W'(res_idx_q);
  assign entry_count_o = CNT_OUT_W'(count_q);

endmodule

`default_nettype wire

// ----- design/mac_address_learning_table_core.sv -----
// ----------------------------------------------------------------------------
// MAC address learning table core
// Learns peer MAC addresses in arrival order and answers lookups by scanning.
// ----------------------------------------------------------------------------
// Scan: a miss reads every filled entry and a hit on entry k reads entries zero
// to k, one store read at a time, so a lookup takes longer as the table fills;
// the single store read port sets this.
// Throughput: one item at a time; the next item can be accepted in the cycle
// after the previous one is resolved, even while its result still waits.
// Reset clears the fill count and all handshake state; the store is not cleared.
`default_nettype none

module mac_address_learning_table_core #(
  parameter int TABLE_ENTRIES = mlt_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          command_i,
  input  wire logic [mlt_pkg::MAC_W-1:0]     mac_address_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               hit_o,
  output logic                               added_o,
  output logic                               table_full_o,
  output logic [mlt_pkg::IDX_OUT_W-1:0]      entry_index_o,
  output logic [mlt_pkg::CNT_OUT_W-1:0]      entry_count_o
);
  import mlt_pkg::*;

  // The controller only sees command and status; all table and result storage
  // lives in the datapath.
  dp_cmd_t cmd;
  dp_sts_t sts;

  mlt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // The datapath scans the filled entries in order, so the first match wins,
  // and appends on a miss when the item asks for it and room remains.
  mlt_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .command_i     (command_i),
    .mac_address_i (mac_address_i),
    .hit_o         (hit_o),
    .added_o       (added_o),
    .table_full_o  (table_full_o),
    .entry_index_o (entry_index_o),
    .entry_count_o (entry_count_o)
  );

  // A result is never both a hit and a newly added entry.
  a_hit_excl_added: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && added_o))
    else $error("result flags both hit and added");

  // A failed add reports no hit and index zero.
  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && table_full_o) |-> (!hit_o && !added_o && (entry_index_o == '0)))
    else $error("full result carries hit, added or an index");

  // Once an item is taken the scan starts, and no second item enters.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled during scan");

endmodule

`default_nettype wire

// ----- sim/tb_mac_address_learning_table_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC address learning table core testbench
// Drives lookup and add-if-absent items into the table, mirrors the table in
// a local predictor and compares every result item field by field. A short
// directed table covers the empty table, the address extremes and the hit,
// miss and append cases. A long random part then fills the table to its end
// and keeps hammering it once it is full. Random gaps and stalls are applied
// on both channels.
// ----------------------------------------------------------------------------

module tb_mac_address_learning_table_core;

  import mlt_pkg::*;

  localparam int ENTRIES      = TABLE_ENTRIES_DEF;
  localparam int RANDOM_ITEMS = 2000;
  // Cycles without any accepted item before the run is declared hung. The
  // slowest correct stretch is a long sender gap plus a full scan plus a long
  // receiver stall, and this leaves a wide margin.
  localparam int IDLE_LIMIT   = 2000;
  // The deepest scan plus the write cycle, with some slack.
  localparam int DRAIN_CYCLES = 40;

  localparam logic [MAC_W-1:0] MAC_ZERO = '0;
  localparam logic [MAC_W-1:0] MAC_ONES = '1;

  // One result item as the block reports it.
  typedef struct packed {
    logic                 hit;
    logic                 added;
    logic                 full;
    logic [IDX_OUT_W-1:0] idx;
    logic [CNT_OUT_W-1:0] cnt;
  } table_reply_t;

  // One row of the directed part. Where lit is set, the expected result is
  // taken from reply instead of from the predictor.
  typedef struct {
    logic             cmd;
    logic [MAC_W-1:0] mac;
    bit               lit;
    table_reply_t     reply;
  } directed_row_t;

  // Clock, reset and block inputs, all known from time zero.
  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             in_valid_i    = 1'b0;
  logic             command_i     = CMD_LOOKUP;
  logic [MAC_W-1:0] mac_address_i = '0;
  logic             out_stall_i   = 1'b0;

  logic                 in_stall_o;
  logic                 out_valid_o;
  logic                 hit_o;
  logic                 added_o;
  logic                 table_full_o;
  logic [IDX_OUT_W-1:0] entry_index_o;
  logic [CNT_OUT_W-1:0] entry_count_o;

  // Local copy of the table. Only entries below known_fill are ever read.
  logic [MAC_W-1:0] known_macs [ENTRIES];
  int               known_fill = 0;

  table_reply_t   pending_replies [$];
  directed_row_t  directed_rows   [$];
  int             error_count = 0;
  int             idle_cycles = 0;
  // While quiet is set, neither side inserts gaps or stalls.
  bit             quiet = 1'b0;
  int             stall_run = 0;
  logic           stall_level = 1'b0;

  mac_address_learning_table_core #(
    .TABLE_ENTRIES(ENTRIES)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .mac_address_i (mac_address_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hit_o         (hit_o),
    .added_o       (added_o),
    .table_full_o  (table_full_o),
    .entry_index_o (entry_index_o),
    .entry_count_o (entry_count_o)
  );

  always #1 clk_i = ~clk_i;

  // Predicts the result of one accepted item and updates the local table.
  // The filled entries are searched from the bottom and the first match wins.
  // A miss on an add appends the address unless the table is already full.
  function automatic table_reply_t predict_table_reply(input logic cmd,
                                                       input logic [MAC_W-1:0] mac);
    table_reply_t r;
    int           n;
    r = '0;
    n = known_fill;
    for (int i = 0; i < n; i++) begin
      if (!r.hit && known_macs[i] == mac) begin
        r.hit = 1'b1;
        r.idx = IDX_OUT_W'(i);
      end
    end
    if (!r.hit && cmd == CMD_ADD) begin
      if (n < ENTRIES) begin
        known_macs[n] = mac;
        r.idx         = IDX_OUT_W'(n);
        r.added       = 1'b1;
        n++;
      end else begin
        r.full = 1'b1;
      end
    end
    known_fill = n;
    r.cnt      = CNT_OUT_W'(n);
    return r;
  endfunction

  function automatic logic [MAC_W-1:0] random_mac();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[MAC_W-1:0];
  endfunction

  // Picks an address already in the table. The first and the last filled
  // entries are favored, since they are the two ends of the scan.
  function automatic logic [MAC_W-1:0] known_mac();
    int k;
    case ($urandom_range(0, 3))
      0:       k = 0;
      1:       k = known_fill - 1;
      default: k = $urandom_range(0, known_fill - 1);
    endcase
    return known_macs[k];
  endfunction

  // A stored address with one bit flipped, to catch a comparator that
  // ignores some bits.
  function automatic logic [MAC_W-1:0] near_miss_mac();
    logic [MAC_W-1:0] m;
    m = known_mac();
    m[$urandom_range(0, MAC_W - 1)] ^= 1'b1;
    return m;
  endfunction

  // Mostly back-to-back or short gaps, with the odd long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet)   return 0;
    if (r < 55)  return 0;
    if (r < 85)  return $urandom_range(1, 3);
    if (r < 97)  return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Presents one item, starting at a falling edge, and holds it until the
  // block takes it. The expectation is queued at the accepting edge. Returns
  // at the falling edge after acceptance with valid still high, so a
  // back-to-back item changes only the payload.
  task automatic send_item(input logic cmd, input logic [MAC_W-1:0] mac,
                           input bit lit, input table_reply_t lit_reply);
    int           gap;
    table_reply_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    mac_address_i <= mac;
    do @(posedge clk_i); while (in_stall_o);
    r = predict_table_reply(cmd, mac);
    pending_replies.push_back(lit ? lit_reply : r);
    @(negedge clk_i);
  endtask

  task automatic wait_for_replies();
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic add_row(input logic cmd, input logic [MAC_W-1:0] mac, input bit lit,
                         input logic hit, input logic added, input logic full,
                         input int idx, input int cnt);
    directed_row_t row;
    row.cmd   = cmd;
    row.mac   = mac;
    row.lit   = lit;
    row.reply = '{hit, added, full, IDX_OUT_W'(idx), CNT_OUT_W'(cnt)};
    directed_rows.push_back(row);
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      error_count++;
    end
  endtask

  // Result channel stall pattern: runs of ready cycles alternate with runs
  // of stall, most runs short and a few long.
  always @(negedge clk_i) begin
    if (quiet) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_run == 0) begin
        stall_level = ($urandom_range(0, 99) < 40);
        if (!stall_level)
          stall_run = $urandom_range(1, 12);
        else if ($urandom_range(0, 99) < 90)
          stall_run = $urandom_range(1, 3);
        else
          stall_run = $urandom_range(10, 40);
      end
      stall_run--;
      out_stall_i <= stall_level;
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    table_reply_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result, hit %0d added %0d full %0d index %0d count %0d",
                 $time, hit_o, added_o, table_full_o, entry_index_o, entry_count_o);
        error_count++;
      end else begin
        exp_r = pending_replies.pop_front();
        check_field("hit", exp_r.hit, hit_o);
        check_field("added", exp_r.added, added_o);
        check_field("table_full", exp_r.full, table_full_o);
        check_field("entry_index", exp_r.idx, entry_index_o);
        check_field("entry_count", exp_r.cnt, entry_count_o);
      end
    end
  end

  // Watchdog: any accepted item on either channel resets the idle count.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic             cmd;
    logic [MAC_W-1:0] mac;
    int               r;
    bit               is_full;
    table_reply_t     none;

    none = '0;

    // Directed rows. Literal results are given where the table contents make
    // them obvious; the rest go through the predictor.
    // Lookups on the empty table miss with a count of zero.
    add_row(CMD_LOOKUP, MAC_ZERO, 1, 0, 0, 0, 0, 0);
    add_row(CMD_LOOKUP, MAC_ONES, 1, 0, 0, 0, 0, 0);
    // First appends land at entries zero and one.
    add_row(CMD_ADD, MAC_ZERO, 1, 0, 1, 0, 0, 1);
    add_row(CMD_ADD, MAC_ONES, 1, 0, 1, 0, 1, 2);
    // An add of a known address reports the existing entry.
    add_row(CMD_ADD, MAC_ONES, 1, 1, 0, 0, 1, 2);
    add_row(CMD_LOOKUP, MAC_ZERO, 1, 1, 0, 0, 0, 2);
    // Lookup misses just next to the stored extremes.
    add_row(CMD_LOOKUP, 48'h0000_0000_0001, 1, 0, 0, 0, 0, 2);
    add_row(CMD_LOOKUP, 48'h7FFF_FFFF_FFFF, 1, 0, 0, 0, 0, 2);
    add_row(CMD_ADD, 48'h8000_0000_0000, 1, 0, 1, 0, 2, 3);
    add_row(CMD_LOOKUP, 48'h8000_0000_0000, 1, 1, 0, 0, 2, 3);
    add_row(CMD_ADD, 48'h0123_4567_89AB, 1, 0, 1, 0, 3, 4);
    add_row(CMD_LOOKUP, 48'hFEFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0);
    add_row(CMD_ADD, MAC_ZERO, 1, 1, 0, 0, 0, 4);
    add_row(CMD_LOOKUP, 48'h0123_4567_89AA, 0, 0, 0, 0, 0, 0);
    add_row(CMD_ADD, 48'hAAAA_AAAA_AAAA, 0, 0, 0, 0, 0, 0);
    add_row(CMD_ADD, 48'h5555_5555_5555, 0, 0, 0, 0, 0, 0);
    add_row(CMD_LOOKUP, 48'h5555_5555_5555, 0, 0, 0, 0, 0, 0);
    add_row(CMD_LOOKUP, 48'hAAAA_AAAA_AAAB, 0, 0, 0, 0, 0, 0);

    // Reset is held from time zero and released at a falling edge.
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      send_item(directed_rows[i].cmd, directed_rows[i].mac, directed_rows[i].lit,
                directed_rows[i].reply);

    // Random part. Appends of new addresses are kept rare while the table has
    // room, so that many lookups and repeated adds run at every fill level.
    // Once the table is full, new addresses exercise the full case.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // A stretch with no gaps and no stalls on either side.
      quiet = (n >= 600 && n < 750);
      // Halfway, the sender holds off until the table has answered everything.
      if (n == RANDOM_ITEMS / 2) begin
        in_valid_i <= 1'b0;
        wait_for_replies();
        @(negedge clk_i);
      end
      is_full = (known_fill >= ENTRIES);
      r       = $urandom_range(0, 99);
      if (r < (is_full ? 20 : 4)) begin
        cmd = CMD_ADD;
        mac = ($urandom_range(0, 3) == 0) ? near_miss_mac() : random_mac();
      end else if (r < 42) begin
        cmd = CMD_LOOKUP;
        mac = known_mac();
      end else if (r < 58) begin
        cmd = CMD_LOOKUP;
        mac = near_miss_mac();
      end else if (r < 70) begin
        cmd = CMD_LOOKUP;
        mac = random_mac();
      end else if (r < 95) begin
        cmd = CMD_ADD;
        mac = known_mac();
      end else begin
        // Address extremes, both of which are stored by the directed part.
        cmd = CMD_LOOKUP;
        mac = $urandom_range(0, 1) ? MAC_ONES : MAC_ZERO;
      end
      send_item(cmd, mac, 1'b0, none);
    end
    quiet = 1'b0;

    in_valid_i <= 1'b0;
    wait_for_replies();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (pending_replies.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_replies.size());
      error_count++;
    end

    if (error_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/mlt_pkg.sv
design/mlt_ram.sv
design/mlt_ctrl.sv
design/mlt_dp.sv
design/mac_address_learning_table_core.sv
sim/tb_mac_address_learning_table_core.sv
